[design/dhs_pkg.sv]
// ----------------------------------------------------------------------------
// dhs_pkg: shared types and constants of the debounced hold stopwatch
// Field widths, register indexes, debounce edge struct and segment table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhs_pkg;

	localparam int CNT_W     = 16;
	localparam int SECONDS_W = 7;
	localparam int SEG_W     = 7;
	localparam int DIGIT_W   = 4;
	localparam int REG_IDX_W = 1;

	localparam logic [SECONDS_W-1:0] SECONDS_MAX   = 7'd99;
	localparam logic [CNT_W-1:0]     STABILITY_MAX = 16'hFFFF;
	localparam logic [DIGIT_W-1:0]   DIGIT_MAX     = 4'd9;

	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [CNT_W-1:0] TPS_RESET      = 16'd1000;

	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b1;

	typedef struct packed {
		logic rise;
		logic fall;
	} dhs_edge_t;

	// Active-low segment code of one decimal digit
	function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] code;
		case (digit)
			4'd0:    code = 7'h40;
			4'd1:    code = 7'h79;
			4'd2:    code = 7'h24;
			4'd3:    code = 7'h30;
			4'd4:    code = 7'h19;
			4'd5:    code = 7'h12;
			4'd6:    code = 7'h02;
			4'd7:    code = 7'h78;
			4'd8:    code = 7'h00;
			4'd9:    code = 7'h18;
			default: code = 7'h7F;
		endcase
		return code;
	endfunction

endpackage

[design/dhs_tick_if.sv]
// ----------------------------------------------------------------------------
// dhs_tick_if: tick channel
// One millisecond tick per transfer, carrying the sampled switch level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dhs_tick_if;
	logic valid;
	logic ready;
	logic switch_sample;

	modport source (output valid, output switch_sample, input ready);
	modport sink   (input valid, input switch_sample, output ready);
endinterface

[design/dhs_result_if.sv]
// ----------------------------------------------------------------------------
// dhs_result_if: result channel
// Seconds, segment codes and status flags, one transfer per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dhs_result_if;
	import dhs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [SECONDS_W-1:0] elapsed_seconds;
	logic [SEG_W-1:0]     segment_ones;
	logic [SEG_W-1:0]     segment_tens;
	logic                 timing_on;
	logic                 display_update;

	modport source (output valid, output elapsed_seconds, output segment_ones,
		output segment_tens, output timing_on, output display_update, input ready);
	modport sink   (input valid, input elapsed_seconds, input segment_ones,
		input segment_tens, input timing_on, input display_update, output ready);
endinterface

[design/dhs_debounce.sv]
// ----------------------------------------------------------------------------
// dhs_debounce: switch debouncer
// Saturating stability counter; reports stable rising and falling edges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhs_debounce (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic                      sample,
	input  logic [dhs_pkg::CNT_W-1:0] debounce_ticks,
	output dhs_pkg::dhs_edge_t        edges
);
	import dhs_pkg::*;

	logic             raw_q;
	logic             stable_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;
	logic             settle;

	assign count_inc = (count_q < STABILITY_MAX) ? count_q + 1'b1 : count_q;
	// a raw change never settles in the same tick
	assign settle    = (sample == raw_q) && (stable_q != raw_q) &&
		(count_inc >= debounce_ticks);

	assign edges.rise = settle && raw_q;
	assign edges.fall = settle && !raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b0;
			stable_q <= 1'b0;
			count_q  <= '0;
		end else if (advance) begin
			if (sample != raw_q) begin
				raw_q   <= sample;
				count_q <= '0;
			end else begin
				count_q <= count_inc;
				if (settle) begin
					stable_q <= raw_q;
				end
			end
		end
	end

endmodule

[design/debounced_hold_stopwatch.sv]
// ----------------------------------------------------------------------------
// debounced_hold_stopwatch: debounced hold stopwatch with two-digit display
// Each accepted tick's result is registered in the output or skid register.
// Throughput: one tick per cycle unless the skid register is full; a two-entry
// result stage (output plus skid register) keeps ticks flowing while one waits.
// Reset: asynchronous, clears all but result data; registers go to 20 and 1000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounced_hold_stopwatch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          write_en,
	input  logic [dhs_pkg::REG_IDX_W-1:0] reg_index,
	input  logic [dhs_pkg::CNT_W-1:0]     write_data,
	dhs_tick_if.sink                      tick,
	dhs_result_if.source                  result
);
	import dhs_pkg::*;

	typedef struct packed {
		logic [SECONDS_W-1:0] elapsed_seconds;
		logic [SEG_W-1:0]     segment_ones;
		logic [SEG_W-1:0]     segment_tens;
		logic                 timing_on;
		logic                 display_update;
	} dhs_result_t;

	// Configuration registers
	logic [CNT_W-1:0] debounce_q;
	logic [CNT_W-1:0] tps_q;

	// Stopwatch state; seconds are also kept as two decimal digits
	logic [CNT_W-1:0]     tick_cnt_q;
	logic [SECONDS_W-1:0] seconds_q;
	logic [DIGIT_W-1:0]   ones_q;
	logic [DIGIT_W-1:0]   tens_q;
	logic                 timing_q;

	// Result stage
	dhs_result_t out_q;
	logic        out_valid_q;
	dhs_result_t skid_q;
	logic        skid_valid_q;

	logic        accept;
	dhs_edge_t   edges;

	logic [CNT_W:0]       tick_next;
	logic                 second_done;
	logic [CNT_W-1:0]     tick_cnt_n;
	logic [SECONDS_W-1:0] seconds_n;
	logic [DIGIT_W-1:0]   ones_n;
	logic [DIGIT_W-1:0]   tens_n;
	logic                 timing_n;
	logic                 update_n;
	dhs_result_t          res_n;

	// Hold off new ticks only while the skid register is full
	assign tick.ready = !skid_valid_q;
	assign accept     = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			tps_q      <= TPS_RESET;
		end else if (write_en) begin
			case (reg_index)
				REG_DEBOUNCE_TICKS:   debounce_q <= write_data;
				REG_TICKS_PER_SECOND: tps_q      <= write_data;
				default: ;
			endcase
		end
	end

	dhs_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (accept),
		.sample         (tick.switch_sample),
		.debounce_ticks (debounce_q),
		.edges          (edges)
	);

	// Advance the timer under the flag from before this tick, then apply the edge
	assign tick_next   = {1'b0, tick_cnt_q} + 1'b1;
	assign second_done = timing_q && (tick_next >= {1'b0, tps_q});

	always_comb begin
		tick_cnt_n = tick_cnt_q;
		seconds_n  = seconds_q;
		ones_n     = ones_q;
		tens_n     = tens_q;
		timing_n   = timing_q;
		update_n   = 1'b0;
		if (timing_q) begin
			if (second_done) begin
				tick_cnt_n = '0;
				update_n   = 1'b1;
				// clamp at 99, but still flag the elapsed second
				if (seconds_q < SECONDS_MAX) begin
					seconds_n = seconds_q + 1'b1;
					if (ones_q == DIGIT_MAX) begin
						ones_n = '0;
						tens_n = tens_q + 1'b1;
					end else begin
						ones_n = ones_q + 1'b1;
					end
				end
			end else begin
				tick_cnt_n = tick_next[CNT_W-1:0];
			end
		end
		// a rising edge wins over a second counted in the same tick
		if (edges.rise) begin
			tick_cnt_n = '0;
			seconds_n  = '0;
			ones_n     = '0;
			tens_n     = '0;
			timing_n   = 1'b1;
			update_n   = 1'b1;
		end else if (edges.fall) begin
			timing_n = 1'b0;
		end
	end

	always_comb begin
		res_n.elapsed_seconds = seconds_n;
		res_n.segment_ones    = seg_code(ones_n);
		res_n.segment_tens    = seg_code(tens_n);
		res_n.timing_on       = timing_n;
		res_n.display_update  = update_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q <= '0;
			seconds_q  <= '0;
			ones_q     <= '0;
			tens_q     <= '0;
			timing_q   <= 1'b0;
		end else if (accept) begin
			tick_cnt_q <= tick_cnt_n;
			seconds_q  <= seconds_n;
			ones_q     <= ones_n;
			tens_q     <= tens_n;
			timing_q   <= timing_n;
		end
	end

	// Result stage: park the new result in the skid register when the output
	// register is still waiting; refill the output from the skid on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (out_valid_q && !result.ready) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (result.ready || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (out_valid_q && !result.ready) begin
				skid_q <= res_n;
			end else begin
				out_q <= res_n;
			end
		end else if ((result.ready || !out_valid_q) && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.elapsed_seconds = out_q.elapsed_seconds;
	assign result.segment_ones    = out_q.segment_ones;
	assign result.segment_tens    = out_q.segment_tens;
	assign result.timing_on       = out_q.timing_on;
	assign result.display_update  = out_q.display_update;

`ifndef NO_ASSERTIONS
	// the skid register is only ever filled behind a waiting output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// the decimal digits track the binary seconds count
	a_digits_match: assert property (@(posedge clk) disable iff (!arst_n)
		seconds_q == 7'(tens_q) * 7'd10 + 7'(ones_q))
		else $error("seconds digits out of step with seconds count");

	// a stable rising edge starts timing from zero
	a_rise_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && edges.rise) |=> (timing_q && seconds_q == '0 && tick_cnt_q == '0))
		else $error("rising edge did not restart the stopwatch");

	// seconds never pass the clamp
	a_seconds_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		seconds_q <= SECONDS_MAX)
		else $error("seconds count beyond clamp");
`endif

endmodule
